>>> hw/rtl/bqc_pkg.sv
package bqc_pkg;

  localparam int MAX_SECTIONS  = 8;
  localparam int COEFS_PER_SEC = 5;
  localparam int NUM_COEF      = COEFS_PER_SEC * MAX_SECTIONS;
  localparam int NUM_DELAY     = 2 * MAX_SECTIONS;
  localparam int SEC_W         = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_AW       = $clog2(NUM_COEF);
  localparam int DLY_AW        = $clog2(NUM_DELAY);

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int COEF_SHIFT = 27;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int SHIFTED_W  = PROD_W - COEF_SHIFT;
  localparam int ACC_W      = COEF_W + 2;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 4;
  localparam int STEP_W     = 3;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SHIFTED_W-1:0] shifted_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam coef_t   COEF_ONE   = coef_t'(1) <<< COEF_SHIFT;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam coef_t   STATE_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   STATE_MIN  = {1'b1, {(COEF_W-1){1'b0}}};

  // datapath controls, one step of the section sequence
  typedef struct packed {
    logic ld_x;
    logic adv_x;
    logic sel_y;
    logic ld_s1;
    logic ld_s2;
    logic ld_y;
    logic acc1_init;
    logic acc1_sub;
    logic acc2_init;
    logic acc2_sub;
    logic wr_s2;
  } ctl_t;

  function automatic sample_t sat_sample(acc_t v);
    logic [ACC_W-SAMPLE_W:0] hi;
    hi = v[ACC_W-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) return v[SAMPLE_W-1:0];
    else if (v[ACC_W-1]) return SAMPLE_MIN;
    else return SAMPLE_MAX;
  endfunction

  function automatic coef_t sat_state(acc_t v);
    logic [ACC_W-COEF_W:0] hi;
    hi = v[ACC_W-1:COEF_W-1];
    if ((&hi) || !(|hi)) return v[COEF_W-1:0];
    else if (v[ACC_W-1]) return STATE_MIN;
    else return STATE_MAX;
  endfunction

endpackage

>>> hw/rtl/bqc_coef_mem.sv
module bqc_coef_mem (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    we,
  input  logic [bqc_pkg::COEF_AW-1:0] waddr,
  input  bqc_pkg::coef_t          wdata,
  input  logic                    re,
  input  logic [bqc_pkg::COEF_AW-1:0] raddr,
  input  logic                    rd_b0,
  output bqc_pkg::coef_t          rdata
);
  import bqc_pkg::*;

  coef_t                mem [NUM_COEF];
  logic [NUM_COEF-1:0]  valid_r;
  logic [NUM_COEF-1:0]  valid_nxt;
  coef_t                q_r;
  logic                 q_valid_r;
  logic                 q_b0_r;

  always_comb begin
    valid_nxt = valid_r;
    if (we) valid_nxt[waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r       <= mem[raddr];
      q_valid_r <= valid_r[raddr];
      q_b0_r    <= rd_b0;
    end
  end

  // unwritten entries read as pass-through coefficients
  assign rdata = q_valid_r ? q_r : (q_b0_r ? COEF_ONE : '0);

endmodule

>>> hw/rtl/bqc_delay_mem.sv
module bqc_delay_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       we,
  input  logic [bqc_pkg::DLY_AW-1:0] waddr,
  input  bqc_pkg::coef_t             wdata,
  input  logic                       re,
  input  logic [bqc_pkg::DLY_AW-1:0] raddr,
  output bqc_pkg::coef_t             rdata
);
  import bqc_pkg::*;

  coef_t                mem [NUM_DELAY];
  logic [NUM_DELAY-1:0] valid_r;
  logic [NUM_DELAY-1:0] valid_nxt;
  coef_t                q_r;
  logic                 q_valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt = '0;
    end else if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r       <= mem[raddr];
      q_valid_r <= valid_r[raddr];
    end
  end

  // cleared entries read as zero
  assign rdata = q_valid_r ? q_r : '0;

endmodule

>>> hw/rtl/bqc_datapath.sv
module bqc_datapath (
  input  logic             clk,
  input  bqc_pkg::ctl_t    ctl,
  input  bqc_pkg::sample_t sample,
  input  bqc_pkg::coef_t   coef,
  input  bqc_pkg::coef_t   dly,
  output bqc_pkg::sample_t y,
  output bqc_pkg::coef_t   dly_wdata
);
  import bqc_pkg::*;

  sample_t  x_r;
  sample_t  y_r;
  coef_t    s1_r;
  coef_t    s2_r;
  prod_t    prod_r;
  prod_t    prod_nxt;
  acc_t     acc1_r;
  acc_t     acc2_r;
  sample_t  mul_opnd;
  shifted_t prod_sh;
  acc_t     sh_ext;
  acc_t     y_sum;

  assign mul_opnd = ctl.sel_y ? y_r : x_r;
  assign prod_nxt = prod_t'(coef) * prod_t'(mul_opnd);

  // arithmetic shift by 27 is a floor, so just drop the low bits
  assign prod_sh = prod_r[PROD_W-1:COEF_SHIFT];
  assign sh_ext  = ACC_W'(prod_sh);
  assign y_sum   = sh_ext + ACC_W'(s1_r);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.ld_x) begin
      x_r <= sample;
    end else if (ctl.adv_x) begin
      x_r <= y_r;
    end
    if (ctl.ld_s1) s1_r <= dly;
    if (ctl.ld_s2) s2_r <= dly;
    if (ctl.ld_y) y_r <= sat_sample(y_sum);
    if (ctl.acc1_init) begin
      acc1_r <= sh_ext + ACC_W'(s2_r);
    end else if (ctl.acc1_sub) begin
      acc1_r <= acc1_r - sh_ext;
    end
    if (ctl.acc2_init) begin
      acc2_r <= sh_ext;
    end else if (ctl.acc2_sub) begin
      acc2_r <= acc2_r - sh_ext;
    end
  end

  assign y         = y_r;
  assign dly_wdata = ctl.wr_s2 ? sat_state(acc2_r) : sat_state(acc1_r);

endmodule

>>> hw/rtl/biquad_cascade_filter.sv
// Cascade of second-order IIR sections (transposed direct form II), Q1.23
// samples, Q5.27 coefficients.
// Input channel (in_valid / in_stall) carries one command per transfer:
// filter a sample, load one coefficient, or clear all delay states.
// Loads and clears complete in the cycle of the transfer and give no result.
// A filtered sample runs through the active sections one after another,
// each section running on a single 32x24 multiplier fed from the
// coefficient and delay memories (five products and two state write-backs).
// The block takes no new command while a sample runs through it; the next
// command is taken in the cycle the result appears on the out_ channel.
// The result sits in an output register: a new command is taken while it
// waits, and only the end of the following sample holds while out_stall is
// high.
// Reset clears all delay states, sets every section to pass-through and
// the section count to one. cfg_we writes the section count; zero acts as
// one and values above eight act as eight.
module biquad_cascade_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bqc_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bqc_pkg::CMD_W-1:0]    in_cmd,
  input  bqc_pkg::sample_t             in_sample_in,
  input  logic                         in_frame_end,
  input  logic [bqc_pkg::IDX_W-1:0]    in_coef_index,
  input  bqc_pkg::coef_t               in_coef_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bqc_pkg::sample_t             out_sample_out,
  output logic                         out_frame_end_out
);
  import bqc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [STEP_W-1:0] STP_RD   = 3'd0;
  localparam logic [STEP_W-1:0] STP_S1   = 3'd1;
  localparam logic [STEP_W-1:0] STP_Y    = 3'd2;
  localparam logic [STEP_W-1:0] STP_N1   = 3'd3;
  localparam logic [STEP_W-1:0] STP_N2   = 3'd4;
  localparam logic [STEP_W-1:0] STP_FB1  = 3'd5;
  localparam logic [STEP_W-1:0] STP_FB2  = 3'd6;
  localparam logic [STEP_W-1:0] STP_LAST = 3'd7;

  logic               state_r, state_nxt;
  logic [STEP_W-1:0]  st_r, st_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [SEC_W-1:0]   last_r, last_nxt;
  logic               frame_r, frame_nxt;
  logic [CNT_W-1:0]   sections_r;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_sample_r;
  logic               out_frame_r;

  logic               in_xfer;
  logic               run;
  logic               sec_done;
  logic               out_free;
  logic               out_load;
  logic [SEC_W-1:0]   last_calc;
  ctl_t               ctl;

  logic               coef_we;
  logic [COEF_AW-1:0] coef_raddr;
  logic               coef_re;
  coef_t              coef_rdata;
  logic               dly_clr;
  logic               dly_we;
  logic               dly_re;
  logic [DLY_AW-1:0]  dly_addr;
  coef_t              dly_rdata;
  coef_t              dly_wdata;
  sample_t            y;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign run      = (state_r == ST_RUN);
  assign sec_done = run && (st_r == STP_LAST);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = sec_done && (sec_r == last_r) && out_free;

  always_comb begin
    if (sections_r == '0) begin
      last_calc = '0;
    end else if (32'(sections_r) > MAX_SECTIONS) begin
      last_calc = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_calc = SEC_W'(sections_r - CNT_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    sec_nxt   = sec_r;
    last_nxt  = last_r;
    frame_nxt = frame_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_cmd == CMD_FILTER) begin
          state_nxt  = ST_RUN;
          st_nxt     = STP_RD;
          sec_nxt    = '0;
          last_nxt   = last_calc;
          frame_nxt  = in_frame_end;
          ctl.ld_x   = 1'b1;
        end
      end
      ST_RUN: begin
        ctl.ld_s1     = (st_r == STP_S1);
        ctl.ld_s2     = (st_r == STP_Y);
        ctl.ld_y      = (st_r == STP_Y);
        ctl.acc1_init = (st_r == STP_N1);
        ctl.acc2_init = (st_r == STP_N2);
        ctl.acc1_sub  = (st_r == STP_FB1);
        ctl.acc2_sub  = (st_r == STP_FB2);
        ctl.sel_y     = (st_r == STP_N2) || (st_r == STP_FB1);
        ctl.wr_s2     = (st_r == STP_LAST);
        if (st_r != STP_LAST) begin
          st_nxt = st_r + STEP_W'(1);
        end else if (sec_r != last_r) begin
          st_nxt    = STP_RD;
          sec_nxt   = sec_r + SEC_W'(1);
          ctl.adv_x = 1'b1;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      st_r        <= STP_RD;
      sec_r       <= '0;
      last_r      <= '0;
      sections_r  <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      sec_r       <= sec_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) sections_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (out_load) begin
      out_sample_r <= y;
      out_frame_r  <= frame_r;
    end
  end

  // coefficient slot follows the step while the five reads go out
  assign coef_we    = in_xfer && (in_cmd == CMD_LOAD) &&
                      (32'(in_coef_index) < NUM_COEF);
  assign coef_re    = run && (st_r <= STP_N2);
  assign coef_raddr = COEF_AW'(sec_r) * COEF_AW'(COEFS_PER_SEC) + COEF_AW'(st_r);

  // s1 read at step 0 and written at step 6, s2 at steps 1 and 7
  assign dly_clr  = in_xfer && (in_cmd == CMD_CLEAR);
  assign dly_re   = run && (st_r <= STP_S1);
  assign dly_we   = run && ((st_r == STP_FB2) || (st_r == STP_LAST));
  assign dly_addr = DLY_AW'({sec_r, st_r[0]});

  bqc_coef_mem u_coef_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (coef_we),
    .waddr (COEF_AW'(in_coef_index)),
    .wdata (in_coef_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rd_b0 (st_r == STP_RD),
    .rdata (coef_rdata)
  );

  bqc_delay_mem u_delay_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (dly_clr),
    .we    (dly_we),
    .waddr (dly_addr),
    .wdata (dly_wdata),
    .re    (dly_re),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  bqc_datapath u_datapath (
    .clk       (clk),
    .ctl       (ctl),
    .sample    (in_sample_in),
    .coef      (coef_rdata),
    .dly       (dly_rdata),
    .y         (y),
    .dly_wdata (dly_wdata)
  );

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_frame_end_out = out_frame_r;

endmodule
